// File: hw/rtl/mbps_pkg.sv
// Shared types and constants for the masked byte pattern scanner.
// Used by mbps_window_match and masked_byte_pattern_scan_top.
`default_nettype none

package mbps_pkg;

   // Size limits
   localparam int PATTERN_MAX = 16;   // deepest window the scanner supports
   localparam int CFG_BYTES   = 16;   // pattern bytes held by the two pattern registers
   localparam int ADDR_W      = 32;   // address arithmetic width

   // Longest usable pattern and the widths that follow from it
   localparam int LEN_MAX = (PATTERN_MAX < CFG_BYTES) ? PATTERN_MAX : CFG_BYTES;
   localparam int LEN_W   = $clog2(LEN_MAX + 1);
   localparam int LIDX_W  = (LEN_MAX > 1) ? $clog2(LEN_MAX) : 1;

   // Port widths fixed by the field layout
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int MASK_W     = 16;
   localparam int PLEN_W     = 5;
   localparam int OUT_ADDR_W = 32;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LOW  = 3'd0,
      CSR_PATTERN_HIGH = 3'd1,
      CSR_MATCH_MASK   = 3'd2,
      CSR_PATTERN_LEN  = 3'd3,
      CSR_BASE_ADDR    = 3'd4,
      CSR_RESULT_OFS   = 3'd5
   } csr_index_type;

   typedef logic [7:0] byte_type;

   // Recent bytes, entry 0 newest
   typedef byte_type window_type [LEN_MAX];

   // Pattern bytes, entry 0 first
   typedef byte_type pattern_type [LEN_MAX];

   // One result item
   typedef struct packed {
      logic                  found;
      logic [OUT_ADDR_W-1:0] addr;
   } result_type;

endpackage

`default_nettype wire

// File: hw/rtl/mbps_window_match.sv
// Parallel masked compare of the byte window against the pattern.
// Depends on mbps_pkg for window, pattern and width definitions.
`default_nettype none

module mbps_window_match (
   input  mbps_pkg::window_type             window,
   input  mbps_pkg::pattern_type            pattern,
   input  logic [mbps_pkg::LEN_MAX-1:0]     mask,
   input  logic [mbps_pkg::LEN_W-1:0]       used_len,
   output logic                             hit
);
   import mbps_pkg::*;

   // Pattern byte k lines up with window entry used_len-1-k
   always_comb begin
      logic [LEN_W-1:0] idx;
      hit = 1'b1;
      for (int k = 0; k < LEN_MAX; k++) begin
         idx = used_len - LEN_W'(1) - LEN_W'(k);
         if ((LEN_W'(k) < used_len) && mask[k] &&
             (window[idx[LIDX_W-1:0]] != pattern[k])) begin
            hit = 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/masked_byte_pattern_scan_top.sv
// Masked byte pattern scanner, top level: configuration registers, byte
// window, region tracking and the two-entry result buffer.
// Depends on mbps_pkg and mbps_window_match.
//
// The scanner takes one byte of a memory region per req item, in address
// order, with req_tlast on the region's final byte, and gives exactly one
// rsp item per region: found=1 with the match start address plus
// result_offset at the first window that matches under the mask, or found=0
// at the last byte if nothing matched. Bytes after a match give no item.
// One item is accepted every cycle while req_tready is high; a result is
// registered in the output register, or in the skid entry if that is held.
// The window shift, the masked compare of all pattern bytes and the 32-bit
// address sum all fit between the input handshake and the result register.
// Results go through a two-entry buffer, so req_tready drops only while
// both entries hold results that the sink has not taken. Configuration is
// to be written only while the scanner is idle; the block does not check it.
`default_nettype none

module masked_byte_pattern_scan_top (
   input  logic                                clock,
   input  logic                                reset,
   // Input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] data_byte
   input  logic                                req_tlast,   // last_byte
   // Result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata,   // [31:0] match_address
   output logic                                rsp_tuser,   // found
   // Configuration writes
   input  logic                                csr_wr_en,
   input  logic [mbps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mbps_pkg::*;

   localparam int FILL_W = LEN_W;

   // Configuration registers
   logic [63:0]         pat_low_ff;
   logic [63:0]         pat_high_ff;
   logic [MASK_W-1:0]   mask_ff;
   logic [PLEN_W-1:0]   plen_ff;
   logic [31:0]         base_ff;
   logic [31:0]         offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         mask_ff     <= '1;
         plen_ff     <= PLEN_W'(1);
         base_ff     <= '0;
         offset_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PATTERN_LOW:  pat_low_ff  <= csr_wdata;
            CSR_PATTERN_HIGH: pat_high_ff <= csr_wdata;
            CSR_MATCH_MASK:   mask_ff     <= csr_wdata[MASK_W-1:0];
            CSR_PATTERN_LEN:  plen_ff     <= csr_wdata[PLEN_W-1:0];
            CSR_BASE_ADDR:    base_ff     <= csr_wdata[31:0];
            CSR_RESULT_OFS:   offset_ff   <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // Effective length: zero counts as one, clamp to the longest pattern
   logic [LEN_W-1:0] used_len;
   always_comb begin
      if (plen_ff == '0) begin
         used_len = LEN_W'(1);
      end else if (32'(plen_ff) > 32'(LEN_MAX)) begin
         used_len = LEN_W'(LEN_MAX);
      end else begin
         used_len = LEN_W'(plen_ff);
      end
   end

   // Pattern bytes and mask bits in use
   logic [127:0]              pat_flat;
   pattern_type               pattern;
   logic [LEN_MAX-1:0]        mask_used;
   assign pat_flat = {pat_high_ff, pat_low_ff};
   always_comb begin
      for (int k = 0; k < LEN_MAX; k++) begin
         pattern[k]   = pat_flat[8*k +: 8];
         mask_used[k] = mask_ff[k];
      end
   end

   // Region state: window, byte count (position after the newest byte),
   // valid fill and done flag
   window_type          window_ff;
   window_type          window_in;
   logic [ADDR_W-1:0]   pos_ff;
   logic [ADDR_W-1:0]   pos_in;
   logic [FILL_W-1:0]   fill_ff;
   logic [FILL_W-1:0]   fill_in;
   logic                done_ff;
   logic                done_in;

   logic                req_acc;
   logic                hit;
   logic                new_valid;
   result_type          new_result;
   logic [ADDR_W-1:0]   start_sum;

   assign req_acc = req_tvalid && req_tready;

   // Window after this byte is shifted in
   always_comb begin
      window_in[0] = req_tdata;
      for (int i = 1; i < LEN_MAX; i++) begin
         window_in[i] = window_ff[i-1];
      end
   end

   assign pos_in  = pos_ff + ADDR_W'(1);
   assign fill_in = (fill_ff == FILL_W'(LEN_MAX)) ? fill_ff : fill_ff + FILL_W'(1);

   mbps_window_match u_match (
      .window   (window_in),
      .pattern  (pattern),
      .mask     (mask_used),
      .used_len (used_len),
      .hit      (hit)
   );

   // Match start plus offset, position already counts the new byte
   assign start_sum = ADDR_W'(base_ff) + ADDR_W'(offset_ff) + pos_in - ADDR_W'(used_len);

   // Result caused by this item
   always_comb begin
      new_valid  = 1'b0;
      new_result = '0;
      done_in    = done_ff;
      if (req_acc && !done_ff) begin
         if ((fill_in >= FILL_W'(used_len)) && hit) begin
            new_valid        = 1'b1;
            new_result.found = 1'b1;
            new_result.addr  = OUT_ADDR_W'(start_sum);
            done_in          = 1'b1;
         end else if (req_tlast) begin
            new_valid = 1'b1;
         end
      end
   end

   // Region state update; the last byte starts a fresh region
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         fill_ff <= '0;
         done_ff <= 1'b0;
      end else if (req_acc) begin
         if (req_tlast) begin
            pos_ff  <= '0;
            fill_ff <= '0;
            done_ff <= 1'b0;
         end else if (!done_ff) begin
            pos_ff  <= pos_in;
            fill_ff <= fill_in;
            done_ff <= done_in;
         end
      end
   end

   // Window bytes are only compared once filled, so no reset
   always_ff @(posedge clock) begin
      if (req_acc && !done_ff) begin
         window_ff <= window_in;
      end
   end

   // Two-entry result buffer: output register plus skid entry
   logic        out_valid_ff;
   result_type  out_ff;
   logic        skid_valid_ff;
   result_type  skid_ff;
   logic        out_take;

   assign out_take   = out_valid_ff && rsp_tready;
   assign req_tready = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || out_take) begin
         out_valid_ff <= new_valid;
      end else if (new_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_ff <= skid_ff;
         end
      end else if (!out_valid_ff || out_take) begin
         out_ff <= new_result;
      end else if (new_valid) begin
         skid_ff <= new_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.found;
   assign rsp_tdata  = out_ff.addr;

   // Checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a result while the output register is empty");

   a_miss_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.found) |-> (out_ff.addr == '0))
      else $error("no-match result carries a nonzero address");

   a_region_clears: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tlast) |=> (!done_ff && (pos_ff == '0) && (fill_ff == '0)))
      else $error("region state not cleared after the last byte");

   a_hit_sets_done: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !req_tlast && new_valid) |=> done_ff)
      else $error("match result did not end the scan of the region");

   a_no_result_after_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !new_valid)
      else $error("result produced after the region already gave one");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(LEN_MAX))
      else $error("window fill count exceeds window depth");

endmodule

`default_nettype wire
